// File: rtl/gqi_pkg.sv
// Types, constants and helper functions for the gyro quaternion integrator.
`default_nettype none
package gqi_pkg;

	localparam int QuatWidth = 32;
	localparam int RateWidth = 32;
	localparam int StepWidth = 24;
	// floor(1e-12 in units of 2^-58)
	localparam logic [62:0] NORM_LIMIT = 63'd288230;

	typedef enum logic {
		OP_INTEGRATE = 1'b0,
		OP_LOAD      = 1'b1
	} op_t;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] rate_x;
		logic signed [31:0] rate_y;
		logic signed [31:0] rate_z;
		logic        [23:0] time_step;
		logic signed [31:0] load_x;
		logic signed [31:0] load_y;
		logic signed [31:0] load_z;
		logic signed [31:0] load_w;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic signed [31:0] quat_w;
		logic               was_normalized;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROT_SET,
		ST_ROT_MUL,
		ST_ROT_ACC,
		ST_DT_SET,
		ST_DT_MUL,
		ST_DT_ACC,
		ST_SQ_SET,
		ST_SQ_MUL,
		ST_SQ_SUM,
		ST_NORM_CHK,
		ST_SQRT,
		ST_DIV_SET,
		ST_DIV,
		ST_DIV_END,
		ST_OUT
	} state_t;

	// Quaternion component feeding term k (rate x, y, z) of component i.
	function automatic logic [1:0] quat_sel(input logic [1:0] i, input logic [1:0] k);
		logic [1:0] r;
		r = 2'd0;
		case (i)
			2'd0: r = (k == 2'd0) ? 2'd3 : ((k == 2'd1) ? 2'd2 : 2'd1);
			2'd1: r = (k == 2'd0) ? 2'd2 : ((k == 2'd1) ? 2'd3 : 2'd0);
			2'd2: r = (k == 2'd0) ? 2'd1 : ((k == 2'd1) ? 2'd0 : 2'd3);
			default: r = (k == 2'd0) ? 2'd0 : ((k == 2'd1) ? 2'd1 : 2'd2);
		endcase
		return r;
	endfunction

	// Term k of component i enters with a minus sign.
	function automatic logic coef_neg(input logic [1:0] i, input logic [1:0] k);
		logic r;
		r = 1'b0;
		case (i)
			2'd0: r = (k == 2'd1);
			2'd1: r = (k == 2'd2);
			2'd2: r = (k == 2'd0);
			default: r = 1'b1;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic signed [31:0] clamp42(input logic signed [41:0] v);
		logic signed [31:0] r;
		if (v > 42'sd2147483647) r = 32'sh7fffffff;
		else if (v < -42'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/gyro_quaternion_integrator.sv
// Top level: gyro quaternion integrator with bit-serial datapath.
//
// Input channel in_valid/in_ready/in_data carries one beat per operation.
// Output channel out_valid/out_ready/out_data carries one beat per input beat.
// A load beat stores the four load fields and returns them as its output beat.
// An integrate beat runs four lanes of shift-add multipliers, one bit per cycle:
// three rate products, one time-step product and one square per lane, then a
// 32-step bit-pair square root and a 31-step restoring divide per lane. An
// integrate beat whose magnitude is below threshold skips the square root and
// the divide and goes straight to the output.
// One beat is in work at a time; in_ready is high only while idle.
// The result sits in an output register; while the receiver stalls the block
// takes one more beat, holds its finished result in its last state and then
// takes no new beat.
// Reset sets the quaternion to identity (w = 1.0) and clears out_valid.
`default_nettype none
module gyro_quaternion_integrator
	import gqi_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_beat_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_beat_t      out_data
);

	localparam logic [4:0] MUL_LAST  = 5'd31;
	localparam logic [4:0] SQRT_LAST = 5'd31;
	localparam logic [4:0] DIV_LAST  = 5'd30;

	state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic [1:0] k_q;
	logic out_valid_q;
	logic in_fire, out_load;

	logic signed [31:0] q_q [4];
	logic signed [31:0] w_q [3];
	logic [23:0] dt_q;
	logic signed [40:0] d_q [4];
	logic [40:0] mc_q [4];
	logic [40:0] ph_q [4];
	logic [31:0] pl_q [4];
	logic [63:0] rad_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] dr_q [4];
	logic [30:0] dn_q [4];
	logic [30:0] quo_q [4];
	logic sat_q [4];
	logic norm_q;
	out_beat_t out_q;

	assign in_fire = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = (in_data.operation == OP_LOAD) ? ST_OUT : ST_ROT_SET;
			end
			ST_ROT_SET: state_d = ST_ROT_MUL;
			ST_ROT_MUL: if (cnt_q == MUL_LAST) state_d = ST_ROT_ACC;
			ST_ROT_ACC: state_d = (k_q == 2'd2) ? ST_DT_SET : ST_ROT_SET;
			ST_DT_SET: state_d = ST_DT_MUL;
			ST_DT_MUL: if (cnt_q == MUL_LAST) state_d = ST_DT_ACC;
			ST_DT_ACC: state_d = ST_SQ_SET;
			ST_SQ_SET: state_d = ST_SQ_MUL;
			ST_SQ_MUL: if (cnt_q == MUL_LAST) state_d = ST_SQ_SUM;
			ST_SQ_SUM: state_d = ST_NORM_CHK;
			ST_NORM_CHK: state_d = (rad_q[62:0] > NORM_LIMIT) ? ST_SQRT : ST_OUT;
			ST_SQRT: if (cnt_q == SQRT_LAST) state_d = ST_DIV_SET;
			ST_DIV_SET: state_d = ST_DIV;
			ST_DIV: if (cnt_q == DIV_LAST) state_d = ST_DIV_END;
			ST_DIV_END: state_d = ST_OUT;
			ST_OUT: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
			if (state_q == ST_IDLE) k_q <= 2'd0;
			else if (state_q == ST_ROT_ACC) k_q <= k_q + 2'd1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// orientation state needs a reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q[0] <= '0;
			q_q[1] <= '0;
			q_q[2] <= '0;
			q_q[3] <= 32'sh40000000;
		end else begin
			if (in_fire && in_data.operation == OP_LOAD) begin
				q_q[0] <= in_data.load_x;
				q_q[1] <= in_data.load_y;
				q_q[2] <= in_data.load_z;
				q_q[3] <= in_data.load_w;
			end else if (state_q == ST_DT_ACC) begin
				for (int i = 0; i < 4; i++) begin
					logic [38:0] inc;
					logic signed [41:0] q42, i42;
					inc = {ph_q[i][31:0], pl_q[i][31:25]};
					q42 = {{10{q_q[i][31]}}, q_q[i]};
					i42 = {3'b000, inc};
					q_q[i] <= clamp42(d_q[i][40] ? q42 - i42 : q42 + i42);
				end
			end else if (state_q == ST_DIV_END) begin
				for (int i = 0; i < 4; i++) begin
					if (sat_q[i]) q_q[i] <= q_q[i][31] ? 32'sh80000000 : 32'sh7fffffff;
					else q_q[i] <= q_q[i][31] ? -$signed({1'b0, quo_q[i]}) : $signed({1'b0, quo_q[i]});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			w_q[0] <= in_data.rate_x;
			w_q[1] <= in_data.rate_y;
			w_q[2] <= in_data.rate_z;
			dt_q <= in_data.time_step;
			norm_q <= 1'b0;
			for (int i = 0; i < 4; i++) d_q[i] <= '0;
		end
		unique case (state_q)
			ST_ROT_SET: begin
				for (int i = 0; i < 4; i++) begin
					mc_q[i] <= {9'd0, mag32(q_q[quat_sel(2'(i), k_q)])};
					ph_q[i] <= '0;
					pl_q[i] <= mag32(w_q[k_q]);
				end
			end
			ST_ROT_MUL, ST_DT_MUL, ST_SQ_MUL: begin
				// add multiplicand on the low bit, shift the pair right
				for (int i = 0; i < 4; i++) begin
					logic [41:0] t;
					t = {1'b0, ph_q[i]} + (pl_q[i][0] ? {1'b0, mc_q[i]} : 42'd0);
					ph_q[i] <= t[41:1];
					pl_q[i] <= {t[0], pl_q[i][31:1]};
				end
			end
			ST_ROT_ACC: begin
				for (int i = 0; i < 4; i++) begin
					logic [38:0] r;
					logic neg;
					r = {ph_q[i][30:0], pl_q[i][31:24]};
					neg = q_q[quat_sel(2'(i), k_q)][31] ^ w_q[k_q][31] ^ coef_neg(2'(i), k_q);
					d_q[i] <= neg ? d_q[i] - $signed({2'b00, r}) : d_q[i] + $signed({2'b00, r});
				end
			end
			ST_DT_SET: begin
				for (int i = 0; i < 4; i++) begin
					mc_q[i] <= d_q[i][40] ? 41'(-d_q[i]) : d_q[i];
					ph_q[i] <= '0;
					pl_q[i] <= {8'd0, dt_q};
				end
			end
			ST_SQ_SET: begin
				for (int i = 0; i < 4; i++) begin
					mc_q[i] <= {9'd0, mag32(q_q[i])};
					ph_q[i] <= '0;
					pl_q[i] <= mag32(q_q[i]);
				end
			end
			ST_SQ_SUM: begin
				logic [62:0] s;
				s = '0;
				for (int i = 0; i < 4; i++) s = s + {2'b00, ph_q[i][30:0], pl_q[i][31:2]};
				rad_q <= {1'b0, s};
				rem_q <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				logic [34:0] rt, tr;
				rt = {rem_q[32:0], rad_q[63:62]};
				tr = {1'b0, root_q, 2'b01};
				if (rt >= tr) begin
					rem_q <= rt - tr;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q <= rt;
					root_q <= {root_q[30:0], 1'b0};
				end
				rad_q <= {rad_q[61:0], 2'b00};
			end
			ST_DIV_SET: begin
				for (int i = 0; i < 4; i++) begin
					logic [31:0] m;
					m = mag32(q_q[i]);
					sat_q[i] <= {2'b00, m} >= {root_q, 2'b00};
					dr_q[i] <= {2'b00, m[31:2]};
					dn_q[i] <= {m[1:0], 29'd0};
					quo_q[i] <= '0;
				end
			end
			ST_DIV: begin
				for (int i = 0; i < 4; i++) begin
					logic [32:0] t;
					t = {dr_q[i], dn_q[i][30]};
					if (t >= {1'b0, root_q}) begin
						dr_q[i] <= 32'(t - {1'b0, root_q});
						quo_q[i] <= {quo_q[i][29:0], 1'b1};
					end else begin
						dr_q[i] <= t[31:0];
						quo_q[i] <= {quo_q[i][29:0], 1'b0};
					end
					dn_q[i] <= {dn_q[i][29:0], 1'b0};
				end
			end
			ST_DIV_END: norm_q <= 1'b1;
			default: ;
		endcase
		if (out_load) begin
			out_q.quat_x <= q_q[0];
			out_q.quat_y <= q_q[1];
			out_q.quat_z <= q_q[2];
			out_q.quat_w <= q_q[3];
			out_q.was_normalized <= norm_q;
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("block took a beat while busy");
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (root_q != 32'd0))
		else $error("divide with zero magnitude");
	a_tiny_skips_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NORM_CHK && rad_q[62:0] <= NORM_LIMIT) |=> (state_q == ST_OUT))
		else $error("tiny magnitude entered normalization");
`endif

endmodule
`default_nettype wire

// File: bench/gyro_quaternion_integrator_tb.sv
// Self-checking bench for the gyro quaternion integrator: predicted orientation vs. output beats.
`default_nettype none
module gyro_quaternion_integrator_tb;
	import gqi_pkg::*;

	localparam int QMAX = 2147483647;
	localparam int QMIN = -2147483648;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1900;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	out_beat_t out_data;

	gyro_quaternion_integrator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	in_beat_t pending_beats[$];
	out_beat_t expected_quats[$];
	longint orient[4];
	int mismatches;
	int idle_cycles;
	bit calm_phase;
	bit long_hold_req;
	bit in_accepted;
	int in_gap;
	int out_gap;
	int hold_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint sat_quat(input longint v);
		if (v > QMAX) return QMAX;
		if (v < QMIN) return QMIN;
		return v;
	endfunction

	function automatic longint abs64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// product cut by s bits, rounding toward zero
	function automatic longint mul_trunc(input longint a, input longint b, input int s);
		longint unsigned r;
		r = (longint'(abs64(a)) * longint'(abs64(b))) >> s;
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// advance the orientation by one beat and return the expected output beat
	function automatic out_beat_t step_orientation(input in_beat_t b);
		out_beat_t r;
		longint wx, wy, wz, d[4], inc, m;
		longint unsigned sumsq, mag, q;
		r.was_normalized = 1'b0;
		if (b.operation == OP_LOAD) begin
			orient[0] = longint'(b.load_x);
			orient[1] = longint'(b.load_y);
			orient[2] = longint'(b.load_z);
			orient[3] = longint'(b.load_w);
		end else begin
			wx = longint'(b.rate_x);
			wy = longint'(b.rate_y);
			wz = longint'(b.rate_z);
			d[0] = mul_trunc(orient[3], wx, 24) - mul_trunc(orient[2], wy, 24)
				+ mul_trunc(orient[1], wz, 24);
			d[1] = mul_trunc(orient[2], wx, 24) + mul_trunc(orient[3], wy, 24)
				- mul_trunc(orient[0], wz, 24);
			d[2] = -mul_trunc(orient[1], wx, 24) + mul_trunc(orient[0], wy, 24)
				+ mul_trunc(orient[3], wz, 24);
			d[3] = -mul_trunc(orient[0], wx, 24) - mul_trunc(orient[1], wy, 24)
				- mul_trunc(orient[2], wz, 24);
			sumsq = 0;
			for (int i = 0; i < 4; i++) begin
				inc = mul_trunc(d[i], longint'({40'd0, b.time_step}), 25);
				orient[i] = sat_quat(orient[i] + inc);
				m = abs64(orient[i]);
				sumsq += (longint'(m) * longint'(m)) >> 2;
			end
			if (sumsq > NORM_LIMIT) begin
				mag = floor_sqrt(sumsq);
				if (mag != 0) begin
					for (int i = 0; i < 4; i++) begin
						q = (longint'(abs64(orient[i])) << 29) / mag;
						orient[i] = sat_quat(orient[i] < 0 ? -longint'(q) : longint'(q));
					end
					r.was_normalized = 1'b1;
				end
			end
		end
		r.quat_x = orient[0][31:0];
		r.quat_y = orient[1][31:0];
		r.quat_z = orient[2][31:0];
		r.quat_w = orient[3][31:0];
		return r;
	endfunction

	function automatic in_beat_t rand_beat(input bit op);
		in_beat_t b;
		b.operation = op;
		b.rate_x = $urandom;
		b.rate_y = $urandom;
		b.rate_z = $urandom;
		b.time_step = 24'($urandom);
		b.load_x = $urandom;
		b.load_y = $urandom;
		b.load_z = $urandom;
		b.load_w = $urandom;
		return b;
	endfunction

	// realistic gyro sample: modest rate, short step
	function automatic in_beat_t gyro_beat();
		in_beat_t b;
		b = rand_beat(OP_INTEGRATE);
		b.rate_x = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
		b.rate_y = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
		b.rate_z = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
		b.time_step = 24'($urandom_range(0, 24'h00_ffff));
		return b;
	endfunction

	function automatic in_beat_t load_beat(input int x, input int y, input int z, input int w);
		in_beat_t b;
		b = rand_beat(OP_LOAD);
		b.load_x = x;
		b.load_y = y;
		b.load_z = z;
		b.load_w = w;
		return b;
	endfunction

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_gap <= 0;
		end else if (in_valid && !in_accepted) begin
			// hold the beat
		end else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (!calm_phase && !in_valid && $urandom_range(0, 7) == 0) begin
			in_gap <= $urandom_range(1, 14);
		end else if (pending_beats.size() > 0) begin
			in_valid <= 1'b1;
			in_data <= pending_beats.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver back-pressure
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap <= 0;
			hold_count <= 0;
		end else if (long_hold_req && hold_count == 0) begin
			hold_count <= 3000;
			out_ready <= 1'b0;
		end else if (hold_count > 1) begin
			hold_count <= hold_count - 1;
		end else if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			out_gap <= $urandom_range(0, 13);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor and predictor
	always @(posedge clk) begin
		in_accepted <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_quats.push_back(step_orientation(in_data));
			if (out_valid && out_ready) begin
				if (expected_quats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output beat %p", out_data);
				end else if (out_data !== expected_quats[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", expected_quats[0], out_data);
					void'(expected_quats.pop_front());
				end else begin
					void'(expected_quats.pop_front());
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("gyro_quaternion_integrator_tb failed");
				$finish;
			end
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		calm_phase = 0;
		long_hold_req = 0;
		orient[0] = 0;
		orient[1] = 0;
		orient[2] = 0;
		orient[3] = 64'sd1 << 30;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: integrate from identity, extremes, loads, tiny magnitude
		pending_beats.push_back(gyro_beat());
		pending_beats.push_back(load_beat(0, 0, 0, 0));
		pending_beats.push_back(gyro_beat());
		pending_beats.push_back(load_beat(1, 0, 0, 0));
		pending_beats.push_back(gyro_beat());
		pending_beats.push_back(load_beat(QMAX, QMAX, QMAX, QMAX));
		begin
			in_beat_t b;
			b = rand_beat(OP_INTEGRATE);
			b.rate_x = QMAX; b.rate_y = QMAX; b.rate_z = QMAX;
			b.time_step = 24'hffffff;
			pending_beats.push_back(b);
			pending_beats.push_back(load_beat(QMIN, QMIN, QMIN, QMIN));
			b.rate_x = QMIN; b.rate_y = QMIN; b.rate_z = QMIN;
			pending_beats.push_back(b);
			b.rate_x = QMIN; b.rate_y = QMAX; b.rate_z = 0;
			pending_beats.push_back(b);
			b.time_step = 0;
			pending_beats.push_back(b);
			pending_beats.push_back(load_beat(QMIN, QMAX, QMIN, QMAX));
			b.rate_x = QMAX; b.rate_y = QMIN; b.rate_z = QMAX;
			b.time_step = 24'hffffff;
			pending_beats.push_back(b);
		end
		pending_beats.push_back(load_beat(32'sh4000_0000, 0, 0, 0));
		pending_beats.push_back(rand_beat(OP_INTEGRATE));
		pending_beats.push_back(rand_beat(OP_LOAD));
		pending_beats.push_back(rand_beat(OP_INTEGRATE));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			while (pending_beats.size() > 8) @(posedge clk);
			if (n == 300) long_hold_req = 1;
			if (n == 310) long_hold_req = 0;
			if (n == RANDOM_ITEMS - 200) calm_phase = 1;
			case ($urandom_range(0, 19))
				0, 1: pending_beats.push_back(rand_beat(OP_LOAD));
				2: pending_beats.push_back(rand_beat(OP_INTEGRATE));
				3: pending_beats.push_back(load_beat($urandom_range(0, 3) - 1, 0,
					$urandom_range(0, 1), 0));
				default: pending_beats.push_back(gyro_beat());
			endcase
		end
		while (pending_beats.size() > 0 || in_valid) @(posedge clk);
		while (expected_quats.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_quats.size() == 0)
			$display("gyro_quaternion_integrator_tb passed");
		else
			$display("gyro_quaternion_integrator_tb failed");
		$finish;
	end
endmodule
`default_nettype wire
